[src/pqs_pkg.sv]
package pqs_pkg;

   localparam int REQ_W = 2;
   localparam int ITEM_W = 8;
   localparam int PRIO_W = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W = 7;

   localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
   localparam logic [REQ_W-1:0] REQ_POP = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PEEK = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_POP,
      OP_PEEK,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [ITEM_W-1:0]   item;
      logic [PRIO_W-1:0]   prio;
   } cmd_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_SCAN,
      B_LAST,
      B_DONE
   } bst_type;

endpackage

[src/priority_queue_scan_unit.sv]
// Push, unknown request codes, and pop/peek on an empty queue: the result is registered from the idle state.
// Pop/peek: every used slot is scanned in B_SCAN, one slot read per cycle from the slot memory, then B_LAST, B_DONE.
// One request is worked at a time; a two-entry command queue takes further transfers meanwhile.
// Synchronous active-high reset clears counts, maximum and control; slot memory is not cleared
// since only slots below the fill count are ever examined.
module priority_queue_scan_unit #(
   parameter int DEPTH = 64,
   parameter int ITEM_BITS = 8,
   parameter int PRIO_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pqs_pkg::REQ_W-1:0]    req_type,
   input  logic [pqs_pkg::ITEM_W-1:0]   req_push_item,
   input  logic [pqs_pkg::PRIO_W-1:0]   req_push_priority,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pqs_pkg::ITEM_W-1:0]   rsp_out_item,
   output logic [pqs_pkg::STATUS_W-1:0] rsp_status,
   output logic [pqs_pkg::COUNT_W-1:0]  rsp_active_count,
   output logic [pqs_pkg::COUNT_W-1:0]  rsp_filled_count,
   output logic [pqs_pkg::PRIO_W-1:0]   rsp_top_priority_seen
);
   import pqs_pkg::*;

   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   pqs_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_push_item     (req_push_item),
      .req_push_priority (req_push_priority),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_take          (cmd_take)
   );

   pqs_back #(
      .DEPTH     (DEPTH),
      .ITEM_BITS (ITEM_BITS),
      .PRIO_BITS (PRIO_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cmd_valid             (cmd_valid),
      .cmd                   (cmd),
      .cmd_take              (cmd_take),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_item          (rsp_out_item),
      .rsp_status            (rsp_status),
      .rsp_active_count      (rsp_active_count),
      .rsp_filled_count      (rsp_filled_count),
      .rsp_top_priority_seen (rsp_top_priority_seen)
   );

endmodule

[src/pqs_front.sv]
module pqs_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [pqs_pkg::REQ_W-1:0]  req_type,
   input  logic [pqs_pkg::ITEM_W-1:0] req_push_item,
   input  logic [pqs_pkg::PRIO_W-1:0] req_push_priority,
   output logic                       cmd_valid,
   output pqs_pkg::cmd_type           cmd,
   input  logic                       cmd_take
);
   import pqs_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       take;
   cmd_type    cls;

   always_comb begin
      cls.item = req_push_item;
      cls.prio = req_push_priority;
      unique case (req_type)
         REQ_PUSH: cls.op = OP_PUSH;
         REQ_POP:  cls.op = OP_POP;
         REQ_PEEK: cls.op = OP_PEEK;
         default:  cls.op = OP_NOP;
      endcase
   end

   assign req_stall = (count_ff == 2'd2);
   assign accept = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign take = cmd_take && cmd_valid;
   assign cmd = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

[src/pqs_back.sv]
module pqs_back #(
   parameter int DEPTH = 64,
   parameter int ITEM_BITS = 8,
   parameter int PRIO_BITS = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         cmd_valid,
   input  pqs_pkg::cmd_type             cmd,
   output logic                         cmd_take,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pqs_pkg::ITEM_W-1:0]   rsp_out_item,
   output logic [pqs_pkg::STATUS_W-1:0] rsp_status,
   output logic [pqs_pkg::COUNT_W-1:0]  rsp_active_count,
   output logic [pqs_pkg::COUNT_W-1:0]  rsp_filled_count,
   output logic [pqs_pkg::PRIO_W-1:0]   rsp_top_priority_seen
);
   import pqs_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int WORD_W = 1 + PRIO_BITS + ITEM_BITS;

   // memory word: {popped, priority, item}
   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [WORD_W-1:0] mem_wdata;

   bst_type state_ff, state_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [CNT_W-1:0]     live_ff, live_in;
   logic [PRIO_BITS-1:0] max_ff, max_in;
   logic                 pop_ff, pop_in;
   logic [IDX_W-1:0]     scan_ff, scan_in;
   logic                 chk_vld_ff;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [PRIO_BITS-1:0] best_prio_ff, best_prio_in;
   logic [ITEM_BITS-1:0] best_item_ff, best_item_in;

   logic                 rsp_valid_ff;
   logic [ITEM_W-1:0]    out_item_ff, out_item_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [COUNT_W-1:0]   active_ff, active_in;
   logic [COUNT_W-1:0]   filled_ff, filled_in;
   logic [PRIO_W-1:0]    top_ff, top_in;
   logic                 load_rsp;
   logic                 out_free;

   logic [ITEM_BITS+ITEM_W-1:0] push_item_ext;
   logic [PRIO_BITS+PRIO_W-1:0] push_prio_ext;
   logic [ITEM_BITS-1:0]        push_item_k;
   logic [PRIO_BITS-1:0]        push_prio_k;
   logic [ITEM_W+ITEM_BITS-1:0] best_item_ext;
   logic [PRIO_W+PRIO_BITS-1:0] max_ext;
   logic [COUNT_W+CNT_W-1:0]    live_ext;
   logic [COUNT_W+CNT_W-1:0]    used_ext;

   logic                 rd_popped;
   logic [PRIO_BITS-1:0] rd_prio;
   logic [ITEM_BITS-1:0] rd_item;
   logic                 scan_last;

   assign push_item_ext = {{ITEM_BITS{1'b0}}, cmd.item};
   assign push_prio_ext = {{PRIO_BITS{1'b0}}, cmd.prio};
   assign push_item_k = push_item_ext[ITEM_BITS-1:0];
   assign push_prio_k = push_prio_ext[PRIO_BITS-1:0];
   assign best_item_ext = {{ITEM_W{1'b0}}, best_item_ff};
   assign max_ext = {{PRIO_W{1'b0}}, max_in};
   assign live_ext = {{COUNT_W{1'b0}}, live_in};
   assign used_ext = {{COUNT_W{1'b0}}, used_in};

   assign rd_popped = rd_data_ff[WORD_W-1];
   assign rd_prio = rd_data_ff[WORD_W-2 -: PRIO_BITS];
   assign rd_item = rd_data_ff[ITEM_BITS-1:0];
   assign scan_last = (CNT_W'(scan_ff) + CNT_W'(1)) == used_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      used_in = used_ff;
      live_in = live_ff;
      max_in = max_ff;
      pop_in = pop_ff;
      scan_in = scan_ff;
      found_in = found_ff;
      best_idx_in = best_idx_ff;
      best_prio_in = best_prio_ff;
      best_item_in = best_item_ff;
      cmd_take = 1'b0;
      mem_we = 1'b0;
      mem_waddr = used_ff[IDX_W-1:0];
      mem_wdata = {1'b0, push_prio_k, push_item_k};
      load_rsp = 1'b0;
      out_item_in = '0;
      status_in = ST_OK;

      if (chk_vld_ff && !rd_popped && (!found_ff || rd_prio > best_prio_ff)) begin
         found_in = 1'b1;
         best_idx_in = scan_ff - IDX_W'(1);
         best_prio_in = rd_prio;
         best_item_in = rd_item;
      end

      unique case (state_ff)
         B_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_take = 1'b1;
               case (cmd.op) inside
                  OP_PUSH: begin
                     load_rsp = 1'b1;
                     if (used_ff == CNT_W'(DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we = 1'b1;
                        used_in = used_ff + CNT_W'(1);
                        live_in = live_ff + CNT_W'(1);
                        if (push_prio_k > max_ff) begin
                           max_in = push_prio_k;
                        end
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (live_ff == '0) begin
                        load_rsp = 1'b1;
                        status_in = ST_EMPTY;
                     end else begin
                        pop_in = (cmd.op == OP_POP);
                        scan_in = '0;
                        found_in = 1'b0;
                        state_in = B_SCAN;
                     end
                  end
                  default: begin
                     load_rsp = 1'b1;
                  end
               endcase
            end
         end
         B_SCAN: begin
            scan_in = scan_ff + IDX_W'(1);
            if (scan_last) begin
               state_in = B_LAST;
            end
         end
         B_LAST: begin
            state_in = B_DONE;
         end
         B_DONE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               out_item_in = best_item_ext[ITEM_W-1:0];
               if (pop_ff) begin
                  mem_we = 1'b1;
                  mem_waddr = best_idx_ff;
                  mem_wdata = {1'b1, best_prio_ff, best_item_ff};
                  live_in = live_ff - CNT_W'(1);
               end
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      active_in = live_ext[COUNT_W-1:0];
      filled_in = used_ext[COUNT_W-1:0];
      top_in = max_ext[PRIO_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         used_ff <= '0;
         live_ff <= '0;
         max_ff <= '0;
         chk_vld_ff <= 1'b0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         live_ff <= live_in;
         max_ff <= max_in;
         chk_vld_ff <= (state_ff == B_SCAN);
         found_ff <= found_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pop_ff <= pop_in;
      scan_ff <= scan_in;
      best_idx_ff <= best_idx_in;
      best_prio_ff <= best_prio_in;
      best_item_ff <= best_item_in;
      if (load_rsp) begin
         out_item_ff <= out_item_in;
         status_ff <= status_in;
         active_ff <= active_in;
         filled_ff <= filled_in;
         top_ff <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[scan_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_item = out_item_ff;
   assign rsp_status = status_ff;
   assign rsp_active_count = active_ff;
   assign rsp_filled_count = filled_ff;
   assign rsp_top_priority_seen = top_ff;

endmodule
